// File: hdl/tamc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tamc_pkg
// Types, codes and defaults shared by the temperature alarm mode controller.
// ----------------------------------------------------------------------------
package tamc_pkg;

    localparam int MAX_DIGITS_DEF = 3;

    // operating modes
    localparam logic [2:0] MODE_MAIN    = 3'd0;
    localparam logic [2:0] MODE_KEYCFG  = 3'd1;
    localparam logic [2:0] MODE_TERMCFG = 3'd2;
    localparam logic [2:0] MODE_ALARM   = 3'd3;
    localparam logic [2:0] MODE_HISTORY = 3'd4;

    // item kinds
    localparam logic [1:0] OP_TEMP = 2'd0;
    localparam logic [1:0] OP_KEY  = 2'd1;
    localparam logic [1:0] OP_TERM = 2'd2;

    // keypad codes
    localparam logic [7:0] KEY_CANCEL = 8'd12;
    localparam logic [7:0] KEY_TOGGLE = 8'd13;
    localparam logic [7:0] KEY_HIST   = 8'd14;
    localparam logic [7:0] KEY_ENTER  = 8'd15;
    localparam logic [7:0] KEY_ONE    = 8'd1;
    localparam logic [7:0] KEY_ZERO   = 8'd10;

    // terminal characters
    localparam logic [7:0] CH_GO     = 8'h47; // 'G'
    localparam logic [7:0] CH_CANCEL = 8'h43; // 'C'
    localparam logic [7:0] CH_OK     = 8'h4F; // 'O'
    localparam logic [7:0] CH_STOP   = 8'h53; // 'S'
    localparam logic [7:0] CH_0      = 8'h30; // '0'
    localparam logic [7:0] CH_9      = 8'h39; // '9'

    // display request bit positions
    localparam int DISP_MAIN    = 0;
    localparam int DISP_KEYCFG  = 1;
    localparam int DISP_TERMCFG = 2;
    localparam int DISP_ALARM   = 3;
    localparam int DISP_HISTORY = 4;
    localparam int DISP_TEMP    = 5;
    localparam int DISP_DIGIT   = 6;
    localparam int DISP_ENABLE  = 7;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]  mode;
        logic        alarm_active;
        logic [7:0]  threshold_now;
        logic [7:0]  temperature_now;
        logic        alarm_enabled_now;
        logic [15:0] alarms_counted;
        logic [1:0]  digits_entered;
        logic [7:0]  display_request;
        logic        threshold_store;
    } t_out;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  temperature;
        logic [7:0]  threshold;
        logic        alarm_en;
        logic [15:0] alarm_cnt;
        logic [1:0]  digit_cnt;
    } t_state;

    // input stage towards the update stage
    typedef struct packed {
        logic valid;
        t_in  data;
    } t_in_beat;

endpackage
`default_nettype wire

// File: hdl/temperature_alarm_mode_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// temperature_alarm_mode_controller
// Mode controller for a temperature alarm: samples, keypad codes and
// terminal bytes in, one status result per item out.
// ----------------------------------------------------------------------------
// Each accepted beat gives exactly one result beat, through the input register
// and the output register. The block takes one beat every cycle while the sink
// keeps taking results: an input register feeds a combinational update of the
// mode, threshold, alarm and digit-entry registers, and the result lands in an
// output register that may wait for the sink while the next item is already
// taken. Threshold digits are kept in a MAX_DIGITS-deep buffer and folded on
// commit; display_request and threshold_store are per-item pulses, while the
// other fields report the state after the item.
module temperature_alarm_mode_controller
    import tamc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    t_in_beat w_beat;
    logic     w_take;

    t_state                  r_state;
    t_state                  n_state;
    logic [MAX_DIGITS*4-1:0] r_digits;
    logic [MAX_DIGITS*4-1:0] n_digits;
    t_out                    n_result;
    t_out                    r_result;
    logic                    r_out_valid;

    // advance when an item waits and the result register is free or emptying
    assign w_take = w_beat.valid && (!r_out_valid || i_ready);

    tamc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_take  (w_take),
        .o_beat  (w_beat)
    );

    tamc_update #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_update (
        .i_item   (w_beat.data),
        .i_state  (r_state),
        .i_digits (r_digits),
        .o_state  (n_state),
        .o_digits (n_digits),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode        <= MODE_MAIN;
            r_state.temperature <= '0;
            r_state.threshold   <= '0;
            r_state.alarm_en    <= 1'b1;
            r_state.alarm_cnt   <= '0;
            r_state.digit_cnt   <= '0;
            r_digits            <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            if (w_take) begin
                r_state  <= n_state;
                r_digits <= n_digits;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_result;

endmodule
`default_nettype wire

// File: hdl/tamc_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tamc_in_stage
// Input register: holds one beat until the update stage takes it.
// ----------------------------------------------------------------------------
module tamc_in_stage
    import tamc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in      i_data,
    input  wire logic     i_take,
    output t_in_beat      o_beat
);

    logic r_valid;
    t_in  r_data;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

endmodule
`default_nettype wire

// File: hdl/tamc_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tamc_update
// Next-state and result logic for one item: mode decode, digit entry,
// threshold commit and the temperature / threshold comparison.
// ----------------------------------------------------------------------------
module tamc_update
    import tamc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire t_in                     i_item,
    input  wire t_state                  i_state,
    input  wire logic [MAX_DIGITS*4-1:0] i_digits,
    output t_state                       o_state,
    output logic [MAX_DIGITS*4-1:0]      o_digits,
    output t_out                         o_result
);

    always_comb begin
        t_state     s;
        logic [MAX_DIGITS*4-1:0] dbuf;
        logic [7:0] disp;
        logic       store;
        logic       run_cmp;
        logic       do_cancel;
        logic       do_commit;
        logic       do_stop;
        logic       do_append;
        logic [3:0] dig;
        logic [7:0] v;
        logic [7:0] v_off;
        logic [7:0] t;

        s         = i_state;
        dbuf      = i_digits;
        disp      = '0;
        store     = 1'b0;
        run_cmp   = 1'b0;
        do_cancel = 1'b0;
        do_commit = 1'b0;
        do_stop   = 1'b0;
        do_append = 1'b0;
        dig       = '0;
        v         = i_item.value;
        v_off     = v - CH_0;
        t         = '0;

        case (i_item.opcode)
            OP_TEMP: begin
                if ((s.mode == MODE_MAIN || s.mode == MODE_ALARM) && v != s.temperature) begin
                    s.temperature = v;
                    if (s.mode == MODE_MAIN) begin
                        disp[DISP_TEMP] = 1'b1;
                    end
                    run_cmp = 1'b1;
                end
            end
            OP_KEY: begin
                case (s.mode)
                    MODE_MAIN: begin
                        if (v == KEY_ENTER) begin
                            s.mode = MODE_KEYCFG;
                            disp[DISP_KEYCFG] = 1'b1;
                        end else if (v == KEY_TOGGLE) begin
                            s.alarm_en = !s.alarm_en;
                            disp[DISP_ENABLE] = 1'b1;
                            run_cmp = 1'b1;
                        end else if (v == KEY_HIST) begin
                            s.mode = MODE_HISTORY;
                            disp[DISP_HISTORY] = 1'b1;
                        end
                    end
                    MODE_KEYCFG: begin
                        if (v == KEY_CANCEL) begin
                            do_cancel = 1'b1;
                        end else if (v == KEY_ENTER) begin
                            do_commit = 1'b1;
                        end else if (v >= KEY_ONE && v <= KEY_ZERO) begin
                            do_append = 1'b1;
                            dig = (v == KEY_ZERO) ? 4'd0 : v[3:0];
                        end
                    end
                    MODE_ALARM: begin
                        if (v == KEY_CANCEL) begin
                            do_stop = 1'b1;
                        end
                    end
                    MODE_HISTORY: begin
                        if (v == KEY_ENTER) begin
                            s.mode = MODE_MAIN;
                            disp[DISP_MAIN] = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_TERM: begin
                case (s.mode)
                    MODE_MAIN: begin
                        if (v == CH_GO) begin
                            s.mode = MODE_TERMCFG;
                            disp[DISP_TERMCFG] = 1'b1;
                        end
                    end
                    MODE_TERMCFG: begin
                        if (v == CH_CANCEL) begin
                            do_cancel = 1'b1;
                        end else if (v == CH_OK) begin
                            do_commit = 1'b1;
                        end else if (v >= CH_0 && v <= CH_9) begin
                            do_append = 1'b1;
                            dig = v_off[3:0];
                        end
                    end
                    MODE_ALARM: begin
                        if (v == CH_STOP) begin
                            do_stop = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (do_cancel) begin
            s.mode = MODE_MAIN;
            s.digit_cnt = '0;
            disp[DISP_MAIN] = 1'b1;
        end

        if (do_commit) begin
            // fold held digits, t = t*10 + d, wrapping at 8 bits
            for (int i = 0; i < MAX_DIGITS; i++) begin
                if (2'(i) < i_state.digit_cnt) begin
                    t = 8'((t << 3) + (t << 1) + {4'b0000, i_digits[i*4 +: 4]});
                end
            end
            s.threshold = t;
            s.digit_cnt = '0;
            s.mode = MODE_MAIN;
            store = 1'b1;
            disp[DISP_MAIN] = 1'b1;
            run_cmp = 1'b1;
        end

        if (do_append && i_state.digit_cnt < 2'(MAX_DIGITS)) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                if (i_state.digit_cnt == 2'(i)) begin
                    dbuf[i*4 +: 4] = dig;
                end
            end
            s.digit_cnt = i_state.digit_cnt + 2'd1;
            disp[DISP_DIGIT] = 1'b1;
        end

        if (do_stop) begin
            s.mode = MODE_MAIN;
            s.alarm_en = 1'b0;
            disp[DISP_MAIN] = 1'b1;
            run_cmp = 1'b1;
        end

        if (run_cmp) begin
            if (s.mode == MODE_MAIN) begin
                if (s.temperature >= s.threshold && s.alarm_en) begin
                    s.mode = MODE_ALARM;
                    if (s.alarm_cnt != 16'hFFFF) begin
                        s.alarm_cnt = s.alarm_cnt + 16'd1;
                    end
                    disp[DISP_ALARM] = 1'b1;
                end
            end else if (s.mode == MODE_ALARM) begin
                if (s.temperature < s.threshold) begin
                    s.mode = MODE_MAIN;
                    disp[DISP_MAIN] = 1'b1;
                end
            end
        end

        o_state  = s;
        o_digits = dbuf;

        o_result.mode              = s.mode;
        o_result.alarm_active      = (s.mode == MODE_ALARM);
        o_result.threshold_now     = s.threshold;
        o_result.temperature_now   = s.temperature;
        o_result.alarm_enabled_now = s.alarm_en;
        o_result.alarms_counted    = s.alarm_cnt;
        o_result.digits_entered    = s.digit_cnt;
        o_result.display_request   = disp;
        o_result.threshold_store   = store;
    end

endmodule
`default_nettype wire

// File: hdl/tamc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tamc_checker
// Port-level checks on the result stream of the mode controller.
// ----------------------------------------------------------------------------
module tamc_checker
    import tamc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    a_alarm_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.alarm_active == (o_data.mode == MODE_ALARM)))
        else $error("alarm_active disagrees with mode");

    // a commit always lands in main or, after the comparison, in alarm
    a_store_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.threshold_store
            |-> (o_data.mode == MODE_MAIN || o_data.mode == MODE_ALARM))
        else $error("threshold store outside main or alarm");

    // digits are held only while a threshold is being entered
    a_digits_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.digits_entered != 2'd0
            |-> (o_data.mode == MODE_KEYCFG || o_data.mode == MODE_TERMCFG))
        else $error("digits held outside entry modes");

    a_alarm_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.display_request[DISP_ALARM]
            |-> (o_data.mode == MODE_ALARM && o_data.alarms_counted != 16'd0))
        else $error("alarm screen requested without entering alarm");

endmodule

bind temperature_alarm_mode_controller tamc_checker u_tamc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
`default_nettype wire
